// File: rtl/lspq_pkg.sv
// Shared types, constants and codes for the linear-scan priority queue.
`default_nettype none

package lspq_pkg;

   localparam int PRIO_W        = 16;
   localparam int DATA_W        = 32;
   localparam int OCC_W         = 5;
   localparam int DEPTH_DEFAULT = 16;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_PULL   = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                     req_type;
      logic signed [PRIO_W-1:0] priority_req;
      logic signed [DATA_W-1:0] payload;
   } req_word_type;

   typedef struct packed {
      logic [1:0]               status;
      logic                     pulled_valid;
      logic signed [PRIO_W-1:0] pulled_priority;
      logic signed [DATA_W-1:0] pulled_payload;
      logic                     head_valid;
      logic signed [PRIO_W-1:0] head_priority;
      logic signed [DATA_W-1:0] head_payload;
      logic [OCC_W-1:0]         occupancy;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SCAN,
      ST_DRAIN,
      ST_RESPOND
   } lspq_state_type;

   typedef struct packed {
      logic load_req;
      logic do_insert;
      logic scan_step;
      logic pull_empty;
      logic pull_finish;
      logic respond;
   } lspq_cmd_type;

   typedef struct packed {
      logic is_pull;
      logic empty;
      logic scan_last;
   } lspq_stat_type;

endpackage

`default_nettype wire

// File: rtl/lspq_ctrl.sv
// Controller state machine for the linear-scan priority queue.
`default_nettype none

module lspq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire lspq_pkg::lspq_stat_type stat,
   output lspq_pkg::lspq_cmd_type      cmd
);
   import lspq_pkg::*;

   lspq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = stat.is_pull ? ST_SCAN : ST_INSERT;
            end
         end
         ST_INSERT: begin
            state_in = ST_RESPOND;
         end
         ST_SCAN: begin
            if (stat.empty) begin
               state_in = ST_RESPOND;
            end else if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy         = 1'b0;
            cmd.load_req = start;
         end
         ST_INSERT: begin
            cmd.do_insert = 1'b1;
         end
         ST_SCAN: begin
            cmd.pull_empty = stat.empty;
            cmd.scan_step  = !stat.empty;
         end
         ST_DRAIN: begin
            cmd.pull_finish = 1'b1;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/lspq_dp.sv
// Datapath of the linear-scan priority queue: slot memory, head registers and scan logic.
`default_nettype none

module lspq_dp #(
   parameter int DEPTH = lspq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lspq_pkg::req_word_type req_word,
   input  wire lspq_pkg::lspq_cmd_type cmd,
   output lspq_pkg::lspq_stat_type     stat,
   output logic                        rsp_strobe,
   output lspq_pkg::rsp_word_type      rsp_word
);
   import lspq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Slot memory, one write and one registered read a cycle.
   logic signed [PRIO_W-1:0] prio_mem_ff [DEPTH];
   logic signed [DATA_W-1:0] data_mem_ff [DEPTH];

   req_word_type             req_ff;
   logic [CNT_W-1:0]         fill_ff;
   logic [1:0]               status_ff;
   logic                     head_valid_ff;
   logic [IDX_W-1:0]         head_idx_ff;
   logic signed [PRIO_W-1:0] head_prio_ff;
   logic signed [DATA_W-1:0] head_data_ff;

   logic [IDX_W-1:0]         rd_ptr_ff;
   logic                     rd_valid_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic signed [PRIO_W-1:0] rd_prio_ff;
   logic signed [DATA_W-1:0] rd_data_ff;

   logic                     trk_valid_ff, trk_valid_in;
   logic [IDX_W-1:0]         trk_idx_ff, trk_idx_in;
   logic signed [PRIO_W-1:0] trk_prio_ff, trk_prio_in;
   logic signed [DATA_W-1:0] trk_data_ff, trk_data_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [PRIO_W-1:0] wr_prio;
   logic signed [DATA_W-1:0] wr_data;
   logic                     shift_en;
   logic                     cand;
   logic [IDX_W-1:0]         new_idx;
   logic                     full;
   logic                     ins_wins;
   logic                     pulled;

   assign full = (fill_ff == CNT_W'(DEPTH));

   assign stat.is_pull   = (req_word.req_type == REQ_PULL);
   assign stat.empty     = (fill_ff == '0);
   assign stat.scan_last = (CNT_W'(rd_ptr_ff) == fill_ff - CNT_W'(1));

   // A returned entry other than the one being pulled is a candidate for the
   // new head; entries above the pulled one move down a slot.
   assign cand     = rd_valid_ff && (rd_idx_ff != head_idx_ff);
   assign shift_en = rd_valid_ff && (rd_idx_ff > head_idx_ff);
   assign new_idx  = shift_en ? rd_idx_ff - IDX_W'(1) : rd_idx_ff;

   always_comb begin
      trk_valid_in = trk_valid_ff;
      trk_idx_in   = trk_idx_ff;
      trk_prio_in  = trk_prio_ff;
      trk_data_in  = trk_data_ff;
      if (cand && (!trk_valid_ff || (rd_prio_ff < trk_prio_ff))) begin
         trk_valid_in = 1'b1;
         trk_idx_in   = new_idx;
         trk_prio_in  = rd_prio_ff;
         trk_data_in  = rd_data_ff;
      end
   end

   assign ins_wins = !head_valid_ff || (req_ff.priority_req < head_prio_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = new_idx;
      wr_prio = rd_prio_ff;
      wr_data = rd_data_ff;
      if (cmd.do_insert) begin
         wr_en   = !full;
         wr_addr = fill_ff[IDX_W-1:0];
         wr_prio = req_ff.priority_req;
         wr_data = req_ff.payload;
      end else if (shift_en) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prio_mem_ff[wr_addr] <= wr_prio;
         data_mem_ff[wr_addr] <= wr_data;
      end
      rd_prio_ff <= prio_mem_ff[rd_ptr_ff];
      rd_data_ff <= data_mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_word;
      end
      rd_idx_ff   <= rd_ptr_ff;
      trk_idx_ff  <= trk_idx_in;
      trk_prio_ff <= trk_prio_in;
      trk_data_ff <= trk_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         status_ff     <= STATUS_OK;
         head_valid_ff <= 1'b0;
         head_idx_ff   <= '0;
         head_prio_ff  <= '0;
         head_data_ff  <= '0;
         rd_ptr_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         trk_valid_ff  <= 1'b0;
         rsp_strobe    <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.scan_step;
         trk_valid_ff <= cmd.load_req ? 1'b0 : trk_valid_in;
         rsp_strobe   <= cmd.respond;
         if (cmd.load_req) begin
            status_ff <= STATUS_OK;
            rd_ptr_ff <= '0;
         end
         if (cmd.scan_step) begin
            rd_ptr_ff <= rd_ptr_ff + IDX_W'(1);
         end
         if (cmd.pull_empty) begin
            status_ff <= STATUS_EMPTY;
         end
         if (cmd.do_insert) begin
            if (full) begin
               status_ff <= STATUS_FULL;
            end else begin
               fill_ff       <= fill_ff + CNT_W'(1);
               head_valid_ff <= 1'b1;
               if (ins_wins) begin
                  head_idx_ff  <= fill_ff[IDX_W-1:0];
                  head_prio_ff <= req_ff.priority_req;
                  head_data_ff <= req_ff.payload;
               end
            end
         end
         if (cmd.pull_finish) begin
            fill_ff       <= fill_ff - CNT_W'(1);
            head_valid_ff <= trk_valid_in;
            head_idx_ff   <= trk_idx_in;
            head_prio_ff  <= trk_prio_in;
            head_data_ff  <= trk_data_in;
         end
      end
   end

   // The pulled entry is the head as it stood when the word was accepted.
   logic signed [PRIO_W-1:0] pull_prio_ff;
   logic signed [DATA_W-1:0] pull_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         pull_prio_ff <= head_prio_ff;
         pull_data_ff <= head_data_ff;
      end
   end

   assign pulled = (req_ff.req_type == REQ_PULL) && (status_ff == STATUS_OK);

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_word.status          <= status_ff;
         rsp_word.pulled_valid    <= pulled;
         rsp_word.pulled_priority <= pulled ? pull_prio_ff : '0;
         rsp_word.pulled_payload  <= pulled ? pull_data_ff : '0;
         rsp_word.head_valid      <= head_valid_ff;
         rsp_word.head_priority   <= head_valid_ff ? head_prio_ff : '0;
         rsp_word.head_payload    <= head_valid_ff ? head_data_ff : '0;
         rsp_word.occupancy       <= OCC_W'(fill_ff);
      end
   end

endmodule

`default_nettype wire

// File: rtl/linear_scan_priority_queue_top.sv
// Top level of the linear-scan priority queue: controller and datapath.
`default_nettype none

// Channel        Ports                       Handshake
// request        start, busy, req_word       taken when start is high and busy is low
// response       rsp_strobe, rsp_word        one word per request, shown for one cycle
//
// An insert passes through the insert and respond states; the response strobe is registered.
// A pull passes through the scan, drain and respond states (an empty queue skips drain): the
// slot memory has one read port, and every stored entry is read once in turn.
// Reset empties the queue at once; the slot memory itself is never cleared.
// The receiver cannot stall: each response is valid only while rsp_strobe is high.

module linear_scan_priority_queue_top #(
   parameter int DEPTH = lspq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire lspq_pkg::req_word_type req_word,
   output logic                        rsp_strobe,
   output lspq_pkg::rsp_word_type      rsp_word
);
   import lspq_pkg::*;

   // The controller sequences each request; the datapath holds the slots.
   lspq_cmd_type  cmd;
   lspq_stat_type stat;

   // A pull reads every stored entry once.  The entry that matches the head is
   // returned, entries above it are written one slot lower as they pass, and
   // the earliest lowest priority among the rest becomes the new head.
   lspq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   lspq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the linear-scan priority queue: shadow queue, stimulus and checks.
module tb_top;
   import lspq_pkg::*;

   // The clock runs at 50 MHz. The block is built at its default depth.
   localparam int CLOCK_HALF       = 10;
   localparam int SLOTS            = DEPTH_DEFAULT;
   // A pull keeps busy high only through its scan, drain and respond states,
   // and every sender gap is bounded in send_word, so no correct run comes near
   // this limit; it allows a wide margin.
   localparam int QUIET_LIMIT      = 1000;
   // The random traffic is split evenly over three idling phases.
   localparam int RANDOM_PER_PHASE = 376;

   localparam logic signed [PRIO_W-1:0] PRIO_MAX = {1'b0, {(PRIO_W-1){1'b1}}};
   localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   linear_scan_priority_queue_top #(
      .DEPTH(SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word)
   );

   // Shadow copy of the queue contents, kept in arrival order as the block
   // keeps them. Only slots below shadow_fill are ever read.
   logic signed [PRIO_W-1:0] shadow_prio [SLOTS];
   logic signed [DATA_W-1:0] shadow_data [SLOTS];
   int unsigned              shadow_fill = 0;

   // Response words predicted at acceptance, oldest first.
   rsp_word_type awaited_rsp [$];

   int error_count   = 0;
   int checked_count = 0;
   int insert_count  = 0;
   int pull_count    = 0;
   int full_drops    = 0;
   int empty_pulls   = 0;
   int idle_pct      = 0;
   int quiet_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Slot holding the lowest priority; the strict comparison keeps the
   // earliest arrival when priorities tie.
   function automatic int unsigned lowest_slot();
      int unsigned best;
      best = 0;
      for (int unsigned i = 1; i < shadow_fill; i++) begin
         if (shadow_prio[i] < shadow_prio[best]) begin
            best = i;
         end
      end
      return best;
   endfunction

   // Applies one request word to the shadow queue and returns the response
   // word that the block must produce for it.
   function automatic rsp_word_type queue_step(input req_word_type w);
      rsp_word_type r;
      int unsigned  idx;
      r        = '0;
      r.status = STATUS_OK;
      if (w.req_type == REQ_INSERT) begin
         insert_count++;
         if (shadow_fill >= SLOTS) begin
            // A full queue drops the word and leaves its contents alone.
            r.status = STATUS_FULL;
            full_drops++;
         end else begin
            shadow_prio[shadow_fill] = w.priority_req;
            shadow_data[shadow_fill] = w.payload;
            shadow_fill++;
         end
      end else begin
         pull_count++;
         if (shadow_fill == 0) begin
            r.status = STATUS_EMPTY;
            empty_pulls++;
         end else begin
            idx               = lowest_slot();
            r.pulled_valid    = 1'b1;
            r.pulled_priority = shadow_prio[idx];
            r.pulled_payload  = shadow_data[idx];
            // Later entries move down one slot to close the gap; nothing
            // past the last stored entry is touched.
            for (int unsigned i = idx; i + 1 < shadow_fill; i++) begin
               shadow_prio[i] = shadow_prio[i + 1];
               shadow_data[i] = shadow_data[i + 1];
            end
            shadow_fill--;
         end
      end
      if (shadow_fill > 0) begin
         idx             = lowest_slot();
         r.head_valid    = 1'b1;
         r.head_priority = shadow_prio[idx];
         r.head_payload  = shadow_data[idx];
      end
      r.occupancy = OCC_W'(shadow_fill);
      return r;
   endfunction

   function automatic req_word_type make_word(input logic kind,
                                              input logic signed [PRIO_W-1:0] prio,
                                              input logic signed [DATA_W-1:0] data);
      req_word_type w;
      w.req_type     = kind;
      w.priority_req = prio;
      w.payload      = data;
      return w;
   endfunction

   // Random request word. Priorities are drawn from the extremes, from a
   // narrow band around zero so that ties are frequent, or from the whole
   // range. Pulls carry random fields too, which the block must ignore.
   function automatic req_word_type random_word(input int insert_pct);
      req_word_type w;
      w.req_type = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_PULL;
      case ($urandom_range(3))
         0: begin
            w.priority_req = $urandom_range(1) ? PRIO_MAX : PRIO_MIN;
         end
         1: begin
            w.priority_req = PRIO_W'($urandom_range(4)) - PRIO_W'(2);
         end
         default: begin
            w.priority_req = PRIO_W'($urandom);
         end
      endcase
      w.payload = DATA_W'($urandom);
      return w;
   endfunction

   // Sends one request word. Inputs change only at the falling edge; the
   // word is taken at the first rising edge at which busy is low, and its
   // response is predicted at that moment. Start is left high afterwards,
   // so back-to-back words follow without a gap unless one is drawn.
   task automatic send_word(input req_word_type w);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start = 1'b0;
         // Mostly short gaps, with some long enough to outlast a full scan,
         // so that gaps end in every stage of the block's work.
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end else begin
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
      end
      start    = 1'b1;
      req_word = w;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      awaited_rsp.push_back(queue_step(w));
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic compare_rsp(input rsp_word_type want, input rsp_word_type got);
      checked_count++;
      check_field("status", want.status, got.status);
      check_field("pulled_valid", want.pulled_valid, got.pulled_valid);
      check_field("pulled_priority", want.pulled_priority, got.pulled_priority);
      check_field("pulled_payload", want.pulled_payload, got.pulled_payload);
      check_field("head_valid", want.head_valid, got.head_valid);
      check_field("head_priority", want.head_priority, got.head_priority);
      check_field("head_payload", want.head_payload, got.head_payload);
      check_field("occupancy", want.occupancy, got.occupancy);
   endtask

   // Response checker and watchdog. Everything here samples at the rising
   // edge, before the block's own updates of that edge take effect. A cycle
   // counts as quiet when no request word is taken and no response appears.
   always @(posedge clock) begin : response_check
      rsp_word_type want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: timeout after %0d quiet cycles", quiet_cycles);
            $display("tb_top: done, errors");
            $finish;
         end else if (rsp_strobe) begin
            if (awaited_rsp.size() == 0) begin
               $error("response word with none awaited: %p", rsp_word);
               error_count++;
            end else begin
               want = awaited_rsp.pop_front();
               compare_rsp(want, rsp_word);
            end
         end
      end
   end

   // A pull from the queue straight after reset must report it empty. The
   // ignored fields are set to all ones to show that they have no effect.
   task automatic test_empty_pull();
      send_word(make_word(REQ_PULL, '1, '1));
   endtask

   // Extreme priorities and payloads, with two entries tied at the lowest
   // priority: the earlier of the two must come out first, then the later.
   task automatic test_extremes_and_ties();
      send_word(make_word(REQ_INSERT, PRIO_MAX, DATA_MAX));
      send_word(make_word(REQ_INSERT, PRIO_MIN, DATA_MIN));
      send_word(make_word(REQ_INSERT, PRIO_MIN, '0));
      send_word(make_word(REQ_INSERT, '1, '1));
      send_word(make_word(REQ_PULL, '0, '0));
      send_word(make_word(REQ_PULL, '0, '0));
   endtask

   // Fills the queue to the last slot and then offers one more word, which
   // must be dropped with a full status and leave the contents unchanged.
   task automatic test_fill_to_full();
      while (shadow_fill < SLOTS) begin
         send_word(random_word(100));
      end
      send_word(make_word(REQ_INSERT, PRIO_MIN, DATA_MAX));
   endtask

   // Random traffic. The insert share swings so that the queue travels
   // between empty and full many times: it turns towards filling when
   // empty, towards draining (or pushing against the limit) when full, and
   // drifts at random in between.
   task automatic test_random_traffic(input int gap_pct, input int count);
      int insert_pct;
      idle_pct   = gap_pct;
      insert_pct = 50;
      repeat (count) begin
         if (shadow_fill == 0) begin
            insert_pct = 80;
         end else if (shadow_fill >= SLOTS) begin
            insert_pct = $urandom_range(1) ? 20 : 60;
         end else if ($urandom_range(31) == 0) begin
            insert_pct = $urandom_range(10, 90);
         end
         send_word(random_word(insert_pct));
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed words first, sent back to back.
      idle_pct = 0;
      test_empty_pull();
      test_extremes_and_ties();
      test_fill_to_full();

      // Random words: no sender gaps, gaps in 47 of a hundred words, then
      // in 37 of a hundred. The receiver cannot hold responses off, so
      // there is no stall to apply on that side.
      test_random_traffic(0, RANDOM_PER_PHASE);
      test_random_traffic(47, RANDOM_PER_PHASE);
      test_random_traffic(37, RANDOM_PER_PHASE);
      start = 1'b0;

      // Drain the outstanding responses, then allow a full pull's latency
      // for anything stray to show up.
      while (awaited_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (SLOTS + 8) @(posedge clock);

      $display("tb_top: %0d inserts (%0d dropped on a full queue), %0d pulls (%0d on empty)",
               insert_count, full_drops, pull_count, empty_pulls);
      $display("tb_top: %0d response words checked, sender gap rates 0, 47 and 37 percent",
               checked_count);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
